// ----- rtl/itics_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// itics_pkg
// Shared types, codes and helpers for the interval table block.
// ---------------------------------------------------------------------------
package itics_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int TIME_W = 11;
   localparam int MIN_PER_HOUR = 60;

   localparam logic [2:0] CMD_BOOK = 3'd0;
   localparam logic [2:0] CMD_CANCEL = 3'd1;
   localparam logic [2:0] CMD_XSORT = 3'd2;
   localparam logic [2:0] CMD_ISORT = 3'd3;
   localparam logic [2:0] CMD_SHOW = 3'd4;

   localparam logic [2:0] ST_BOOKED = 3'd0;
   localparam logic [2:0] ST_INVALID = 3'd1;
   localparam logic [2:0] ST_CANCELLED = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_SORTED = 3'd4;
   localparam logic [2:0] ST_ENTRY = 3'd5;
   localparam logic [2:0] ST_EMPTY = 3'd6;
   localparam logic [2:0] ST_FULL = 3'd7;

   localparam logic [0:0] CSR_MIN = 1'd0;
   localparam logic [0:0] CSR_MAX = 1'd1;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_PUSH,
      OP_DELETE,
      OP_XCMP,
      OP_IFIND,
      OP_IMOVE
   } op_type;

   typedef struct packed {
      op_type          op;
      logic [IDX_W-1:0] i;
      logic [IDX_W-1:0] j;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             match;
      logic             less;
   } stat_type;

   // minutes to {minute, hour} with the hour in the low five bits,
   // minutes below 2048
   function automatic logic [10:0] to_hm(input logic [TIME_W-1:0] t);
      logic [5:0]  h;
      logic [19:0] p;
      logic [11:0] r;
      begin
         // 273/16384 sits just under 1/60: the quotient is low by at most one
         p = t * 20'd273;
         h = p[19:14];
         r = {1'b0, t} - h * 12'd60;
         if (r >= 12'd60) begin
            h = h + 6'd1;
            r = r - 12'd60;
         end
         to_hm = {r[5:0], h[4:0]};
      end
   endfunction

endpackage
`default_nettype wire

// ----- rtl/itics_datapath.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// itics_datapath
// Entry table in registers with shift, delete, compare and swap steps.
// ---------------------------------------------------------------------------
module itics_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire itics_pkg::cmd_type              cmd,
   input  wire logic [itics_pkg::TIME_W-1:0]    key_s,
   input  wire logic [itics_pkg::TIME_W-1:0]    key_e,
   output itics_pkg::stat_type                  stat,
   output logic [itics_pkg::TIME_W-1:0]         rd_s,
   output logic [itics_pkg::TIME_W-1:0]         rd_e
);
   localparam int D = itics_pkg::TABLE_DEPTH;
   localparam int W = itics_pkg::TIME_W;

   logic [W-1:0] s_ff [D];
   logic [W-1:0] e_ff [D];
   logic [W-1:0] s_in [D];
   logic [W-1:0] e_in [D];
   logic [itics_pkg::CNT_W-1:0] count_ff, count_in;
   logic [W-1:0] hold_s_ff, hold_s_in, hold_e_ff, hold_e_in;

   assign rd_s = s_ff[cmd.i];
   assign rd_e = e_ff[cmd.i];
   assign stat.count = count_ff;
   assign stat.match = (s_ff[cmd.i] == key_s);
   // exchange: s[i] > s[j]; insertion find: s[j] < held key, but at the
   // head s[0] <= held key, since only a strictly smaller key goes first
   assign stat.less = (cmd.op == itics_pkg::OP_IFIND) ?
                      ((cmd.j == '0) ? (s_ff[0] <= hold_s_ff) : (s_ff[cmd.j] < hold_s_ff)) :
                      (s_ff[cmd.i] > s_ff[cmd.j]);

   // apply one table step
   always_comb begin
      for (int k = 0; k < D; k++) begin
         s_in[k] = s_ff[k];
         e_in[k] = e_ff[k];
      end
      count_in = count_ff;
      hold_s_in = hold_s_ff;
      hold_e_in = hold_e_ff;
      case (cmd.op)
         itics_pkg::OP_PUSH: begin
            for (int k = 1; k < D; k++) begin
               s_in[k] = s_ff[k-1];
               e_in[k] = e_ff[k-1];
            end
            s_in[0] = key_s;
            e_in[0] = key_e;
            count_in = count_ff + 1'b1;
         end
         itics_pkg::OP_DELETE: begin
            for (int k = 0; k < D - 1; k++) begin
               if (k >= cmd.i) begin
                  s_in[k] = s_ff[k+1];
                  e_in[k] = e_ff[k+1];
               end
            end
            count_in = count_ff - 1'b1;
         end
         itics_pkg::OP_XCMP: begin
            if (s_ff[cmd.i] > s_ff[cmd.j]) begin
               s_in[cmd.i] = s_ff[cmd.j];
               e_in[cmd.i] = e_ff[cmd.j];
               s_in[cmd.j] = s_ff[cmd.i];
               e_in[cmd.j] = e_ff[cmd.i];
            end
         end
         itics_pkg::OP_LOAD: begin
            hold_s_in = s_ff[cmd.i];
            hold_e_in = e_ff[cmd.i];
         end
         // shift [j, i) up by one and drop held entry at j
         itics_pkg::OP_IMOVE: begin
            for (int k = 1; k < D; k++) begin
               if (k > cmd.j && k <= cmd.i) begin
                  s_in[k] = s_ff[k-1];
                  e_in[k] = e_ff[k-1];
               end
            end
            s_in[cmd.j] = hold_s_ff;
            e_in[cmd.j] = hold_e_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < D; k++) begin
         s_ff[k] <= s_in[k];
         e_ff[k] <= e_in[k];
      end
      hold_s_ff <= hold_s_in;
      hold_e_ff <= hold_e_in;
      if (reset) count_ff <= '0;
      else count_ff <= count_in;
   end
endmodule
`default_nettype wire

// ----- rtl/itics_control.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// itics_control
// Command sequencer: validates bookings, walks the table and emits results.
// ---------------------------------------------------------------------------
module itics_control (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [2:0]                   req_cmd,
   input  wire logic [itics_pkg::TIME_W-1:0] req_s,
   input  wire logic [itics_pkg::TIME_W-1:0] req_e,
   input  wire logic [10:0]                  min_dur,
   input  wire logic [10:0]                  max_dur,
   output itics_pkg::cmd_type                cmd,
   input  wire itics_pkg::stat_type          stat,
   input  wire logic [itics_pkg::TIME_W-1:0] rd_s,
   input  wire logic [itics_pkg::TIME_W-1:0] rd_e,
   output logic [itics_pkg::TIME_W-1:0]      key_s,
   output logic [itics_pkg::TIME_W-1:0]      key_e,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [2:0]                        rsp_status,
   output logic [21:0]                       rsp_times,
   output logic                              rsp_last
);
   localparam int IW = itics_pkg::IDX_W;
   localparam int CW = itics_pkg::CNT_W;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b00000001,
      S_CANCEL = 8'b00000010,
      S_XSORT  = 8'b00000100,
      S_ILOAD  = 8'b00001000,
      S_IFIND  = 8'b00010000,
      S_IMOVE  = 8'b00100000,
      S_SHOW   = 8'b01000000,
      S_OUT    = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;
   logic [itics_pkg::TIME_W-1:0] ks_ff, ks_in, ke_ff, ke_in;
   logic ov_ff, ov_in;
   logic [2:0] ost_ff, ost_in;
   logic [21:0] otm_ff, otm_in;
   logic olast_ff, olast_in;
   logic [11:0] dur;
   logic book_ok;
   logic out_free;

   assign key_s = ks_ff;
   assign key_e = ke_ff;
   assign rsp_tvalid = ov_ff;
   assign rsp_status = ost_ff;
   assign rsp_times = otm_ff;
   assign rsp_last = olast_ff;
   assign out_free = !ov_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign dur = {1'b0, req_e} - {1'b0, req_s};
   assign book_ok = (req_s < req_e) && (dur[10:0] >= min_dur) && (dur[10:0] <= max_dur);

   always_comb begin
      state_in = state_ff;
      i_in = i_ff;
      j_in = j_ff;
      ks_in = ks_ff;
      ke_in = ke_ff;
      ov_in = ov_ff && !rsp_tready;
      ost_in = ost_ff;
      otm_in = otm_ff;
      olast_in = olast_ff;
      cmd.op = itics_pkg::OP_NONE;
      cmd.i = i_ff[IW-1:0];
      cmd.j = j_ff[IW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               ks_in = req_s;
               ke_in = req_e;
               i_in = '0;
               j_in = CW'(1);
               otm_in = '0;
               olast_in = 1'b1;
               case (req_cmd)
                  itics_pkg::CMD_BOOK: begin
                     ov_in = 1'b1;
                     if (!book_ok) ost_in = itics_pkg::ST_INVALID;
                     else if (stat.count >= CW'(itics_pkg::TABLE_DEPTH))
                        ost_in = itics_pkg::ST_FULL;
                     else begin
                        ost_in = itics_pkg::ST_BOOKED;
                        state_in = S_OUT;
                        ov_in = 1'b0;
                     end
                  end
                  itics_pkg::CMD_CANCEL: state_in = S_CANCEL;
                  itics_pkg::CMD_XSORT: state_in = S_XSORT;
                  itics_pkg::CMD_ISORT: state_in = S_ILOAD;
                  itics_pkg::CMD_SHOW: state_in = S_SHOW;
                  default: ;
               endcase
            end
         end
         // push the booking at the head, then report
         S_OUT: begin
            cmd.op = itics_pkg::OP_PUSH;
            ov_in = 1'b1;
            state_in = S_IDLE;
         end
         S_CANCEL: begin
            if (i_ff >= stat.count) begin
               ost_in = itics_pkg::ST_NOTFOUND;
               ov_in = 1'b1;
               state_in = S_IDLE;
            end else if (stat.match) begin
               cmd.op = itics_pkg::OP_DELETE;
               ost_in = itics_pkg::ST_CANCELLED;
               ov_in = 1'b1;
               state_in = S_IDLE;
            end else i_in = i_ff + 1'b1;
         end
         // one pair (i, j) per cycle
         S_XSORT: begin
            if (i_ff + 1'b1 >= stat.count) begin
               ost_in = itics_pkg::ST_SORTED;
               ov_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.op = itics_pkg::OP_XCMP;
               if (j_ff + 1'b1 >= stat.count) begin
                  i_in = i_ff + 1'b1;
                  j_in = i_ff + CW'(2);
               end else j_in = j_ff + 1'b1;
            end
         end
         // in place: prefix [0, i) is sorted; take entry i
         S_ILOAD: begin
            if (i_ff >= stat.count) begin
               ost_in = itics_pkg::ST_SORTED;
               ov_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.op = itics_pkg::OP_LOAD;
               j_in = '0;
               state_in = S_IFIND;
            end
         end
         S_IFIND: begin
            cmd.op = itics_pkg::OP_IFIND;
            if (i_ff == '0) state_in = S_IMOVE;
            else if (j_ff == '0) begin
               if (stat.less) j_in = CW'(1);
               else state_in = S_IMOVE;
            end else if (j_ff < i_ff && stat.less) j_in = j_ff + 1'b1;
            else state_in = S_IMOVE;
         end
         S_IMOVE: begin
            cmd.op = itics_pkg::OP_IMOVE;
            i_in = i_ff + 1'b1;
            state_in = S_ILOAD;
         end
         S_SHOW: begin
            if (out_free) begin
               if (stat.count == '0) begin
                  ost_in = itics_pkg::ST_EMPTY;
                  ov_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  ost_in = itics_pkg::ST_ENTRY;
                  otm_in = {itics_pkg::to_hm(rd_e), itics_pkg::to_hm(rd_s)};
                  olast_in = (i_ff + 1'b1 == stat.count);
                  ov_in = 1'b1;
                  i_in = i_ff + 1'b1;
                  if (i_ff + 1'b1 == stat.count) state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff <= ov_in;
      end
      i_ff <= i_in;
      j_ff <= j_in;
      ks_ff <= ks_in;
      ke_ff <= ke_in;
      ost_ff <= ost_in;
      otm_ff <= otm_in;
      olast_ff <= olast_in;
   end
endmodule
`default_nettype wire

// ----- rtl/interval_table_insert_cancel_sort.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// interval_table_insert_cancel_sort
// Ordered table of booked time intervals with cancel, two sorts and display.
// ---------------------------------------------------------------------------
// One item at a time. Book accepts the item and then pushes it, cancel scans
// for a matching start, exchange sort compares and swaps every pair (i, j),
// insertion sort loads each entry, runs a find loop over the sorted prefix
// and moves the entry into place, display gives one entry per cycle (up to N
// entries) as the output takes them. The table lives in flip-flops and the
// datapath compares pace the cancel and sort walks.
module interval_table_insert_cancel_sort (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // cmd[2:0], start_hour[7:3], start_minute[13:8], end_hour[18:14],
   // end_minute[24:19], zero fill to 32
   input  wire logic [31:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status[2:0], out_start_hour[7:3], out_start_minute[13:8],
   // out_end_hour[18:14], out_end_minute[24:19], zero fill to 32
   output logic [31:0]      rsp_tdata,
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [10:0] csr_wdata
);
   typedef logic [itics_pkg::TIME_W-1:0] time_w_type;

   logic [10:0] min_ff, max_ff;
   logic [itics_pkg::TIME_W-1:0] req_s, req_e, key_s, key_e, rd_s, rd_e;
   itics_pkg::cmd_type cmd;
   itics_pkg::stat_type stat;
   logic [2:0] st;
   logic [21:0] tm;

   // hold configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= 11'd30;
         max_ff <= 11'd120;
      end else if (csr_we) begin
         if (csr_index == itics_pkg::CSR_MIN) min_ff <= csr_wdata;
         else max_ff <= csr_wdata;
      end
   end

   assign req_s = time_w_type'(req_tdata[7:3] * 11'd60) + {5'd0, req_tdata[13:8]};
   assign req_e = time_w_type'(req_tdata[18:14] * 11'd60) + {5'd0, req_tdata[24:19]};

   itics_control u_ctl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_cmd(req_tdata[2:0]), .req_s(req_s), .req_e(req_e),
      .min_dur(min_ff), .max_dur(max_ff),
      .cmd(cmd), .stat(stat), .rd_s(rd_s), .rd_e(rd_e),
      .key_s(key_s), .key_e(key_e),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_status(st), .rsp_times(tm), .rsp_last(rsp_tlast)
   );

   itics_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .key_s(key_s), .key_e(key_e), .stat(stat), .rd_s(rd_s), .rd_e(rd_e)
   );

   assign rsp_tdata = {7'd0, tm, st};

   // a result on hold keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   // table never overflows
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      stat.count <= itics_pkg::CNT_W'(itics_pkg::TABLE_DEPTH))
      else $error("entry count overflow");
   // only the entry status carries times; every other status has them zero
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != itics_pkg::ST_ENTRY |-> rsp_tdata[24:3] == '0)
      else $error("non-entry result with times");
endmodule
`default_nettype wire

// ----- tb/tb_interval_table_insert_cancel_sort.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_interval_table_insert_cancel_sort
// Drives book, cancel, sort and display items into the interval table and
// checks every result against a table kept in the testbench.
// ---------------------------------------------------------------------------
module tb_interval_table_insert_cancel_sort;

   localparam int STALL_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = itics_pkg::CSR_MIN;
   logic [10:0] csr_wdata = '0;

   typedef struct packed {
      logic [31:0] data;
      logic        tlast;
   } rsp_item_type;

   logic [31:0]  pending_items[$];
   rsp_item_type expected_rsp[$];

   // predicted table
   logic [10:0] tbl_start[itics_pkg::TABLE_DEPTH];
   logic [10:0] tbl_end[itics_pkg::TABLE_DEPTH];
   int          tbl_count;
   logic [10:0] cfg_min;
   logic [10:0] cfg_max;

   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_len = 0;
   int hold_cycles = 0;
   bit hold_taken = 1'b0;
   int quiet_cycles = 0;
   bit bench_done = 1'b0;
   logic req_tready_seen = 1'b0;

   interval_table_insert_cancel_sort u_top (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic rsp_item_type make_rsp(input logic [2:0] status, input bit show,
                                             input logic [10:0] s, input logic [10:0] e,
                                             input bit last);
      rsp_item_type r;
      int sv, ev;
      sv = int'(s);
      ev = int'(e);
      r.data = '0;
      r.data[2:0] = status;
      if (show) begin
         r.data[7:3] = 5'(sv / 60);
         r.data[13:8] = 6'(sv % 60);
         r.data[18:14] = 5'(ev / 60);
         r.data[24:19] = 6'(ev % 60);
      end
      r.tlast = last;
      return r;
   endfunction

   // update the table model and queue the results an item causes
   task automatic predict_table(input logic [31:0] d);
      logic [2:0] cmd;
      int s, e, i, j, p, n, c;
      logic [10:0] ts;
      logic [10:0] ns[itics_pkg::TABLE_DEPTH];
      logic [10:0] ne[itics_pkg::TABLE_DEPTH];
      logic [2:0] st;
      cmd = d[2:0];
      s = int'(d[7:3]) * 60 + int'(d[13:8]);
      e = int'(d[18:14]) * 60 + int'(d[24:19]);
      case (cmd)
         itics_pkg::CMD_BOOK: begin
            if (s >= e || (e - s) < cfg_min || (e - s) > cfg_max) st = itics_pkg::ST_INVALID;
            else if (tbl_count >= itics_pkg::TABLE_DEPTH) st = itics_pkg::ST_FULL;
            else begin
               for (i = tbl_count; i > 0; i--) begin
                  tbl_start[i] = tbl_start[i-1];
                  tbl_end[i] = tbl_end[i-1];
               end
               tbl_start[0] = 11'(s);
               tbl_end[0] = 11'(e);
               tbl_count++;
               st = itics_pkg::ST_BOOKED;
            end
            expected_rsp.push_back(make_rsp(st, 1'b0, '0, '0, 1'b1));
         end
         itics_pkg::CMD_CANCEL: begin
            st = itics_pkg::ST_NOTFOUND;
            for (i = 0; i < tbl_count; i++) begin
               if (st == itics_pkg::ST_NOTFOUND && tbl_start[i] == 11'(s)) begin
                  for (j = i; j + 1 < tbl_count; j++) begin
                     tbl_start[j] = tbl_start[j+1];
                     tbl_end[j] = tbl_end[j+1];
                  end
                  tbl_count--;
                  st = itics_pkg::ST_CANCELLED;
               end
            end
            expected_rsp.push_back(make_rsp(st, 1'b0, '0, '0, 1'b1));
         end
         itics_pkg::CMD_XSORT: begin
            for (i = 0; i + 1 < tbl_count; i++)
               for (j = i + 1; j < tbl_count; j++)
                  if (tbl_start[i] > tbl_start[j]) begin
                     ts = tbl_start[i]; tbl_start[i] = tbl_start[j]; tbl_start[j] = ts;
                     ts = tbl_end[i]; tbl_end[i] = tbl_end[j]; tbl_end[j] = ts;
                  end
            expected_rsp.push_back(make_rsp(itics_pkg::ST_SORTED, 1'b0, '0, '0, 1'b1));
         end
         itics_pkg::CMD_ISORT: begin
            n = 0;
            for (i = 0; i < tbl_count; i++) begin
               c = int'(tbl_start[i]);
               if (n == 0 || c < int'(ns[0])) p = 0;
               else begin
                  p = 1;
                  while (p < n && int'(ns[p]) < c) p++;
               end
               for (j = n; j > p; j--) begin
                  ns[j] = ns[j-1];
                  ne[j] = ne[j-1];
               end
               ns[p] = 11'(c);
               ne[p] = tbl_end[i];
               n++;
            end
            for (i = 0; i < n; i++) begin
               tbl_start[i] = ns[i];
               tbl_end[i] = ne[i];
            end
            expected_rsp.push_back(make_rsp(itics_pkg::ST_SORTED, 1'b0, '0, '0, 1'b1));
         end
         itics_pkg::CMD_SHOW: begin
            if (tbl_count == 0)
               expected_rsp.push_back(make_rsp(itics_pkg::ST_EMPTY, 1'b0, '0, '0, 1'b1));
            else
               for (i = 0; i < tbl_count; i++)
                  expected_rsp.push_back(make_rsp(itics_pkg::ST_ENTRY, 1'b1, tbl_start[i],
                                                  tbl_end[i], i + 1 == tbl_count));
         end
         default: ;
      endcase
   endtask

   function automatic logic [31:0] pack_req(input logic [2:0] cmd, input logic [4:0] sh,
                                            input logic [5:0] sm, input logic [4:0] eh,
                                            input logic [5:0] em);
      return {7'd0, em, eh, sm, sh, cmd};
   endfunction

   // book with a length near the configured range
   function automatic logic [31:0] rand_book();
      int s, e, len;
      s = $urandom_range(0, 1300);
      len = (cfg_max >= cfg_min && $urandom_range(0, 3) != 0) ?
            $urandom_range(cfg_min, cfg_max) : $urandom_range(0, 300);
      e = s + len;
      if (e > 1439) e = 1439;
      if ($urandom_range(0, 9) == 0)
         return pack_req(itics_pkg::CMD_BOOK, 5'($urandom), 6'($urandom), 5'($urandom),
                         6'($urandom));
      return pack_req(itics_pkg::CMD_BOOK, 5'(s / 60), 6'(s % 60), 5'(e / 60), 6'(e % 60));
   endfunction

   function automatic logic [31:0] rand_item();
      int k, idx, s;
      k = $urandom_range(0, 99);
      if (k < 45) return rand_book();
      if (k < 65) begin
         if (tbl_count > 0 && $urandom_range(0, 3) != 0) begin
            idx = $urandom_range(0, tbl_count - 1);
            s = int'(tbl_start[idx]);
            return pack_req(itics_pkg::CMD_CANCEL, 5'(s / 60), 6'(s % 60), 5'($urandom),
                            6'($urandom));
         end
         return pack_req(itics_pkg::CMD_CANCEL, 5'($urandom), 6'($urandom), 5'($urandom),
                         6'($urandom));
      end
      if (k < 75) return pack_req(itics_pkg::CMD_XSORT, 5'($urandom), 6'($urandom), '0, '0);
      if (k < 85) return pack_req(itics_pkg::CMD_ISORT, '0, '0, 5'($urandom), 6'($urandom));
      if (k < 97) return pack_req(itics_pkg::CMD_SHOW, '0, '0, '0, '0);
      return pack_req(3'($urandom_range(5, 7)), 5'($urandom), 6'($urandom), '0, '0);
   endfunction

   // wait for every queued item to be taken and answered, then settle
   task automatic drain();
      while (pending_items.size() != 0 || expected_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic [10:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == itics_pkg::CSR_MIN) cfg_min = val;
      else cfg_max = val;
   endtask

   task automatic run_random(input int count);
      int i;
      for (i = 0; i < count; i++) pending_items.push_back(rand_item());
      drain();
   endtask

   // driver: offer items from the pending queue, hold one until it is taken
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_tready_seen) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_tdata <= pending_items[0];
               predict_table(pending_items[0]);
               void'(pending_items.pop_front());
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // record acceptance at the rising edge for the driver
   always @(posedge clock) begin
      req_tready_seen <= req_tvalid && req_tready;
   end

   // receiver readiness with its own long hold-off
   always @(negedge clock) begin
      if (hold_len > 0 && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_cycles <= hold_len;
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // monitor: check each accepted result against the oldest expectation
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata, '0);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_tdata[2:0] != want.data[2:0])
               report_mismatch("status", 32'(rsp_tdata[2:0]), 32'(want.data[2:0]));
            if (rsp_tdata[7:3] != want.data[7:3])
               report_mismatch("start hour", 32'(rsp_tdata[7:3]), 32'(want.data[7:3]));
            if (rsp_tdata[13:8] != want.data[13:8])
               report_mismatch("start minute", 32'(rsp_tdata[13:8]), 32'(want.data[13:8]));
            if (rsp_tdata[18:14] != want.data[18:14])
               report_mismatch("end hour", 32'(rsp_tdata[18:14]), 32'(want.data[18:14]));
            if (rsp_tdata[24:19] != want.data[24:19])
               report_mismatch("end minute", 32'(rsp_tdata[24:19]), 32'(want.data[24:19]));
            if (rsp_tdata[31:25] != want.data[31:25])
               report_mismatch("fill", 32'(rsp_tdata[31:25]), 32'(want.data[31:25]));
            if (rsp_tlast != want.tlast)
               report_mismatch("last", 32'(rsp_tlast), 32'(want.tlast));
         end
      end
   end

   // watchdog: end the run when nothing is accepted for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset || bench_done)
         quiet_cycles <= 0;
      else if (pending_items.size() != 0 || expected_rsp.size() != 0 || req_tvalid) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_interval_table_insert_cancel_sort failed");
            $finish;
         end
      end
   end

   initial begin
      int i;
      tbl_count = 0;
      cfg_min = 11'd30;
      cfg_max = 11'd120;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty cases, extremes, equal starts for both sorts
      pending_items.push_back(pack_req(itics_pkg::CMD_SHOW, '0, '0, '0, '0));
      pending_items.push_back(pack_req(itics_pkg::CMD_XSORT, '0, '0, '0, '0));
      pending_items.push_back(pack_req(itics_pkg::CMD_ISORT, '0, '0, '0, '0));
      pending_items.push_back(pack_req(itics_pkg::CMD_CANCEL, 5'd3, 6'd0, '0, '0));
      pending_items.push_back(pack_req(itics_pkg::CMD_BOOK, 5'd10, 6'd0, 5'd10, 6'd0));
      pending_items.push_back(pack_req(itics_pkg::CMD_BOOK, 5'd10, 6'd0, 5'd9, 6'd0));
      pending_items.push_back(pack_req(itics_pkg::CMD_BOOK, 5'd10, 6'd0, 5'd10, 6'd29));
      pending_items.push_back(pack_req(itics_pkg::CMD_BOOK, 5'd10, 6'd0, 5'd10, 6'd30));
      pending_items.push_back(pack_req(itics_pkg::CMD_BOOK, 5'd10, 6'd0, 5'd12, 6'd0));
      pending_items.push_back(pack_req(itics_pkg::CMD_BOOK, 5'd10, 6'd0, 5'd12, 6'd1));
      pending_items.push_back(pack_req(itics_pkg::CMD_BOOK, 5'd5, 6'd0, 5'd6, 6'd0));
      pending_items.push_back(pack_req(itics_pkg::CMD_BOOK, 5'd10, 6'd0, 5'd11, 6'd0));
      pending_items.push_back(pack_req(itics_pkg::CMD_BOOK, 5'd0, 6'd0, 5'd1, 6'd0));
      pending_items.push_back(pack_req(itics_pkg::CMD_BOOK, 5'd31, 6'd63, 5'd31, 6'd63));
      pending_items.push_back(pack_req(itics_pkg::CMD_BOOK, 5'd22, 6'd59, 5'd23, 6'd59));
      pending_items.push_back(pack_req(itics_pkg::CMD_SHOW, '0, '0, '0, '0));
      pending_items.push_back(pack_req(itics_pkg::CMD_ISORT, '0, '0, '0, '0));
      pending_items.push_back(pack_req(itics_pkg::CMD_SHOW, '0, '0, '0, '0));
      pending_items.push_back(pack_req(itics_pkg::CMD_BOOK, 5'd10, 6'd0, 5'd10, 6'd45));
      pending_items.push_back(pack_req(itics_pkg::CMD_XSORT, '0, '0, '0, '0));
      pending_items.push_back(pack_req(itics_pkg::CMD_SHOW, '0, '0, '0, '0));
      pending_items.push_back(pack_req(itics_pkg::CMD_CANCEL, 5'd10, 6'd0, '0, '0));
      pending_items.push_back(pack_req(3'd5, '0, '0, '0, '0));
      pending_items.push_back(pack_req(3'd7, 5'd31, 6'd63, 5'd31, 6'd63));
      pending_items.push_back(pack_req(itics_pkg::CMD_SHOW, '0, '0, '0, '0));
      send_idle_pct = 34;
      recv_idle_pct = 50;
      drain();

      // wide range, fill the table to full
      write_csr(itics_pkg::CSR_MIN, 11'd0);
      write_csr(itics_pkg::CSR_MAX, 11'd1439);
      for (i = 0; i < 20; i++) pending_items.push_back(rand_book());
      pending_items.push_back(pack_req(itics_pkg::CMD_SHOW, '0, '0, '0, '0));
      // long receiver hold-off while the sender keeps offering
      hold_len = 600;
      drain();
      run_random(20);

      send_idle_pct = 50;
      recv_idle_pct = 34;
      write_csr(itics_pkg::CSR_MIN, 11'd1439);
      write_csr(itics_pkg::CSR_MAX, 11'd0);
      run_random(10);

      write_csr(itics_pkg::CSR_MIN, 11'd30);
      write_csr(itics_pkg::CSR_MAX, 11'd120);
      run_random(15);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(itics_pkg::CSR_MIN, 11'd1);
      write_csr(itics_pkg::CSR_MAX, 11'd600);
      run_random(25);
      bench_done = 1'b1;

      if (errors == 0) begin
         $display("tb_interval_table_insert_cancel_sort passed");
      end else begin
         $display("tb_interval_table_insert_cancel_sort failed");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
rtl/itics_pkg.sv
rtl/itics_datapath.sv
rtl/itics_control.sv
rtl/interval_table_insert_cancel_sort.sv
tb/tb_interval_table_insert_cancel_sort.sv
